/* hdl/sid_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_pkg
// Shared types and constants for the sorted ID table: command and status
// codes, controller states and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sid_pkg;

  // stream word layout
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int ID_IO_W     = 6;
  localparam int IDX_IO_W    = 6;
  localparam int HANDLE_IO_W = 32;
  localparam int S_TDATA_W   = 48;
  localparam int M_TDATA_W   = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_RM_IDX = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_RM_ID  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_IDX_RD,
    S_IDX_CHK,
    S_SH_INIT,
    S_SHIFT,
    S_FINISH,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic srch_rd;
    logic srch_chk;
    logic idx_rd;
    logic idx_cap;
    logic gap_set;
    logic shift_init;
    logic shift_step;
    logic finish;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  in_op;
    op_t  op;
    logic full;
    logic slot_ok;
    logic srch_done;
    logic hit;
    logic shift_busy;
    logic wr_pend;
    logic out_free;
  } dp_stat_t;

endpackage

/* hdl/sid_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module sid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/sid_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_datapath
// Entry store, search bounds, shift pointers, result and output registers.
// Acts on one command bundle per cycle from the controller.
// ----------------------------------------------------------------------------
module sid_datapath #(
  parameter int ENTRIES     = 64,
  parameter int HANDLE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [sid_pkg::S_TDATA_W-1:0]   s_tdata,
  input  logic [sid_pkg::CMD_W-1:0]       s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [sid_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic [sid_pkg::STATUS_W-1:0]    m_tuser,
  input  sid_pkg::ctl_cmd_t               cmd,
  output sid_pkg::dp_stat_t               stat
);
  import sid_pkg::*;

  localparam int ID_W   = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > ID_IO_W) ? CNT_W : ID_IO_W;
  localparam int HX_W   = (HANDLE_BITS > HANDLE_IO_W) ? HANDLE_BITS : HANDLE_IO_W;
  localparam int WORD_W = ID_W + HANDLE_BITS;
  localparam int PAD_W  = M_TDATA_W - ID_IO_W - IDX_IO_W - HANDLE_IO_W;

  // input word fields
  logic [HANDLE_IO_W-1:0] in_handle;
  logic [IDX_IO_W-1:0]    in_slot;
  logic [ID_IO_W-1:0]     in_key;

  assign in_handle = s_tdata[HANDLE_IO_W-1:0];
  assign in_slot   = s_tdata[HANDLE_IO_W +: IDX_IO_W];
  assign in_key    = s_tdata[HANDLE_IO_W + IDX_IO_W +: ID_IO_W];

  op_t                    op;
  logic [HANDLE_BITS-1:0] hin;
  logic [CMP_W-1:0]       key;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       lo;
  logic [CNT_W-1:0]       hi;
  logic [ID_W-1:0]        mid;
  logic [ID_W-1:0]        pos;
  logic [ID_W-1:0]        src;
  logic [CNT_W-1:0]       moves;
  logic                   wr_pend;
  logic [ID_W-1:0]        wr_addr;
  status_t                res_status;
  logic [ID_W-1:0]        res_id;
  logic [ID_W-1:0]        res_idx;
  logic [HANDLE_BITS-1:0] res_handle;

  // ram ports
  logic                   we;
  logic [ID_W-1:0]        waddr;
  logic [WORD_W-1:0]      wdata;
  logic [ID_W-1:0]        raddr;
  logic [WORD_W-1:0]      rd_word;
  logic [ID_W-1:0]        rd_id;
  logic [HANDLE_BITS-1:0] rd_handle;

  logic [CNT_W-1:0] span;
  logic [CNT_W-1:0] mid_full;
  logic [ID_W-1:0]  mid_c;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] pos_ext;
  logic             is_add;
  logic             hit;
  logic             go_left;
  logic [CMP_W-1:0] id_ext;
  logic [CMP_W-1:0] idx_ext;
  logic [HX_W-1:0]  h_ext;

  assign span     = hi - lo;
  assign mid_full = lo + (span >> 1);
  assign mid_c    = mid_full[ID_W-1:0];
  assign cnt_m1   = count - CNT_W'(1);
  assign pos_ext  = CNT_W'(pos);
  assign is_add   = (op == CMD_ADD);

  assign rd_id     = rd_word[WORD_W-1 -: ID_W];
  assign rd_handle = rd_word[HANDLE_BITS-1:0];

  // add searches for the first slot whose id differs from its index
  assign hit     = !is_add && (CMP_W'(rd_id) == key);
  assign go_left = is_add ? (rd_id != mid) : (key < CMP_W'(rd_id));

  always_comb begin
    priority if (cmd.idx_rd) begin
      raddr = pos;
    end else if (cmd.shift_step) begin
      raddr = src;
    end else begin
      raddr = mid_c;
    end
  end

  assign we    = wr_pend || (cmd.finish && is_add);
  assign waddr = wr_pend ? wr_addr : pos;
  assign wdata = wr_pend ? rd_word : {pos, hin};

  sid_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_word)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      wr_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      wr_pend <= cmd.shift_step && (moves != '0);
      if (cmd.finish) begin
        count <= is_add ? count + CNT_W'(1) : cnt_m1;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign id_ext  = CMP_W'(res_id);
  assign idx_ext = CMP_W'(res_idx);
  assign h_ext   = HX_W'(res_handle);

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op         <= op_t'(s_tuser);
      hin        <= HANDLE_BITS'(in_handle);
      key        <= CMP_W'(in_key);
      lo         <= '0;
      hi         <= count;
      pos        <= ID_W'(in_slot);
      res_status <= (op_t'(s_tuser) == CMD_ADD && stat.full) ? ST_FULL : ST_NOT_FOUND;
      res_id     <= '0;
      res_idx    <= '0;
      res_handle <= '0;
    end
    if (cmd.srch_rd) begin
      mid <= mid_c;
    end
    if (cmd.srch_chk) begin
      if (hit) begin
        pos        <= mid;
        res_status <= ST_OK;
        res_id     <= rd_id;
        res_idx    <= mid;
        res_handle <= rd_handle;
      end else if (go_left) begin
        hi <= CNT_W'(mid);
      end else begin
        lo <= CNT_W'(mid) + CNT_W'(1);
      end
    end
    if (cmd.idx_cap) begin
      res_status <= ST_OK;
      res_id     <= rd_id;
      res_idx    <= pos;
      res_handle <= rd_handle;
    end
    if (cmd.gap_set) begin
      pos        <= lo[ID_W-1:0];
      res_status <= ST_OK;
      res_id     <= lo[ID_W-1:0];
      res_idx    <= lo[ID_W-1:0];
      res_handle <= '0;
    end
    if (cmd.shift_init) begin
      if (is_add) begin
        src   <= cnt_m1[ID_W-1:0];
        moves <= count - pos_ext;
      end else begin
        src   <= pos + ID_W'(1);
        moves <= cnt_m1 - pos_ext;
      end
    end
    if (cmd.shift_step && (moves != '0)) begin
      src     <= is_add ? src - ID_W'(1) : src + ID_W'(1);
      wr_addr <= is_add ? src + ID_W'(1) : src - ID_W'(1);
      moves   <= moves - CNT_W'(1);
    end
    if (cmd.out_load) begin
      m_tdata <= {{PAD_W{1'b0}}, h_ext[HANDLE_IO_W-1:0], idx_ext[IDX_IO_W-1:0],
                  id_ext[ID_IO_W-1:0]};
      m_tuser <= res_status;
    end
  end

  always_comb begin
    stat.in_op      = op_t'(s_tuser);
    stat.op         = op;
    stat.full       = (count == CNT_W'(ENTRIES));
    stat.slot_ok    = (CMP_W'(in_slot) < CMP_W'(count));
    stat.srch_done  = (lo == hi);
    stat.hit        = hit;
    stat.shift_busy = (moves != '0);
    stat.wr_pend    = wr_pend;
    stat.out_free   = !m_tvalid || m_tready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("entry count above capacity");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over an untaken word");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> (CNT_W'(wr_addr) <= count))
    else $error("shift write outside the table");

  a_insert_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !wr_pend)
    else $error("insert write collides with shift write");

endmodule

/* hdl/sid_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_ctrl
// Sequencer for the sorted ID table: binary search, index read, shift walk, insert
// and result hand-off.
// ----------------------------------------------------------------------------
module sid_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  sid_pkg::dp_stat_t  stat,
  output sid_pkg::ctl_cmd_t  cmd
);
  import sid_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          unique case (stat.in_op)
            CMD_ADD:    state_next = stat.full ? S_RESULT : S_SRCH_RD;
            CMD_RM_IDX: state_next = stat.slot_ok ? S_IDX_RD : S_RESULT;
            default:    state_next = S_SRCH_RD;
          endcase
        end
      end
      S_SRCH_RD: begin
        if (stat.srch_done) begin
          if (stat.op == CMD_ADD) begin
            cmd.gap_set = 1'b1;
            state_next  = S_SH_INIT;
          end else begin
            state_next = S_RESULT;
          end
        end else begin
          cmd.srch_rd = 1'b1;
          state_next  = S_SRCH_CHK;
        end
      end
      S_SRCH_CHK: begin
        cmd.srch_chk = 1'b1;
        if (stat.hit) begin
          state_next = (stat.op == CMD_LOOKUP) ? S_RESULT : S_SH_INIT;
        end else begin
          state_next = S_SRCH_RD;
        end
      end
      S_IDX_RD: begin
        cmd.idx_rd = 1'b1;
        state_next = S_IDX_CHK;
      end
      S_IDX_CHK: begin
        cmd.idx_cap = 1'b1;
        state_next  = S_SH_INIT;
      end
      S_SH_INIT: begin
        cmd.shift_init = 1'b1;
        state_next     = S_SHIFT;
      end
      S_SHIFT: begin
        // one entry read per cycle, each written in the next cycle
        cmd.shift_step = 1'b1;
        if (!stat.shift_busy && !stat.wr_pend) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/sorted_id_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_id_table
// Fixed-capacity table of (ID, handle) entries kept in ascending ID order,
// with lowest-free-ID allocation, removal by index or ID and lookup by ID.
// ----------------------------------------------------------------------------
// One command is worked at a time and each gives one result word. The table
// sits in a single RAM with one write and one registered read port, so each
// binary search probe passes through a read state and a check state, and a
// shift moves one entry per cycle. No clearing pass is needed after reset. A
// finished result waits in the output register while the next command is
// taken in; that command then holds at the result stage until the waiting
// word is taken.
module sorted_id_table #(
  parameter int ENTRIES     = 64,
  parameter int HANDLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // handle_in [31:0], slot_index [37:32], key_id [43:38], zero [47:44]
  input  logic [sid_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // cmd [1:0]
  input  logic [sid_pkg::CMD_W-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // id_out [5:0], index_out [11:6], handle_out [43:12], zero [47:44]
  output logic [sid_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // status [1:0]
  output logic [sid_pkg::STATUS_W-1:0]  m_axis_tuser
);
  import sid_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  sid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sid_datapath #(
    .ENTRIES     (ENTRIES),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_axis_tdata),
    .s_tuser  (s_axis_tuser),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .m_tdata  (m_axis_tdata),
    .m_tuser  (m_axis_tuser),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
